// File: rtl/core/first_fit_cell_allocator_macros.svh
// Assertion helpers for the cell allocator.
`ifndef FIRST_FIT_CELL_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_CELL_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS

`define FFCA_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`define FFCA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`define FFCA_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error(msg);

`else

`define FFCA_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define FFCA_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`define FFCA_ASSERT_NEVER(label, clk, rst, cond, msg)

`endif

`endif

// File: rtl/core/ffca_pkg.sv
`default_nettype none

package ffca_pkg;

   localparam int MAX_CELLS = 128;
   localparam int CELL_AW   = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
   localparam int CNT_W     = $clog2(MAX_CELLS + 1);
   localparam int ID_W      = 16;
   localparam int CFG_W     = 8;

   localparam logic [ID_W-1:0]  ID_EXHAUSTED = 16'hFFFF;
   localparam logic [CFG_W-1:0] CELLS_RESET  = 8'd128;

   typedef enum logic [1:0] {
      OP_ALLOC  = 2'd0,
      OP_ERASE  = 2'd1,
      OP_DEFRAG = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_FAIL    = 2'd1,
      ST_ILLEGAL = 2'd2
   } status_type;

endpackage

`default_nettype wire

// File: rtl/core/first_fit_cell_allocator.sv
// Alloc scans the owner store for a free run, then tags it in a fill pass; an early fail
//   skips the scan. Erase scans once; defragment compacts, then clears the tail. Allocs and
//   failed erases answer through a registered response; a good erase or defragment does not.
// Throughput: one request at a time; req_ready is high only while idle.
// Reset: synchronous, active high; a clearing pass frees every cell, during which no request
//   is taken. next_id returns to 1, cells_in_use to 128.
`default_nettype none

module first_fit_cell_allocator (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_opcode,
   input  wire logic [15:0] req_size_or_id,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_status,
   output logic [15:0]      rsp_block_id,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [7:0]  csr_cells_in_use
);

`include "first_fit_cell_allocator_macros.svh"

   localparam int AW = ffca_pkg::CELL_AW;
   localparam int CW = ffca_pkg::CNT_W;
   localparam int IW = ffca_pkg::ID_W;

   typedef enum logic [1:0] {
      S_FILL,
      S_IDLE,
      S_SCAN,
      S_DONE
   } state_type;

   state_type            state_ff, state_in;
   ffca_pkg::op_type     op_ff, op_in;
   logic [IW-1:0]        arg_ff, arg_in;
   logic [CW-1:0]        rd_ptr_ff, rd_ptr_in;
   logic                 rd_vld_ff, rd_vld_in;
   logic [AW-1:0]        rd_idx_ff;
   logic [IW-1:0]        rd_data_ff;
   logic [CW-1:0]        run_ff, run_in;
   logic [CW-1:0]        dst_ff, dst_in;
   logic                 found_ff, found_in;
   logic [CW-1:0]        fill_ptr_ff, fill_ptr_in;
   logic [CW-1:0]        fill_stop_ff, fill_stop_in;
   logic [IW-1:0]        fill_val_ff, fill_val_in;
   logic [IW-1:0]        next_id_ff, next_id_in;
   logic [7:0]           cells_ff;
   ffca_pkg::status_type pend_status_ff, pend_status_in;
   logic [IW-1:0]        pend_id_ff, pend_id_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   ffca_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [IW-1:0]        rsp_id_ff, rsp_id_in;

   logic [CW-1:0]        n_cells;
   logic                 rd_issue;
   logic [AW-1:0]        rd_addr;
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [IW-1:0]        wr_data;
   logic [CW-1:0]        want;
   logic [CW-1:0]        run_inc;
   logic                 scan_end;

   logic [IW-1:0]        owner_mem [ffca_pkg::MAX_CELLS];

   assign n_cells = (32'(cells_ff) > ffca_pkg::MAX_CELLS) ?
                    CW'(ffca_pkg::MAX_CELLS) : CW'(cells_ff);
   assign want     = arg_ff[CW-1:0];
   assign run_inc  = run_ff + CW'(1);
   assign rd_issue = (state_ff == S_SCAN) && (rd_ptr_ff != n_cells);
   assign rd_addr  = rd_ptr_ff[AW-1:0];
   assign scan_end = !rd_vld_ff && (rd_ptr_ff == n_cells);

   assign req_ready    = (state_ff == S_IDLE);
   assign csr_ready    = 1'b1;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_block_id = rsp_id_ff;

   // owner store: one read, one write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         owner_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= owner_mem[rd_addr];
      rd_idx_ff  <= rd_addr;
   end

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      arg_in         = arg_ff;
      rd_ptr_in      = rd_ptr_ff;
      rd_vld_in      = rd_issue;
      run_in         = run_ff;
      dst_in         = dst_ff;
      found_in       = found_ff;
      fill_ptr_in    = fill_ptr_ff;
      fill_stop_in   = fill_stop_ff;
      fill_val_in    = fill_val_ff;
      next_id_in     = next_id_ff;
      pend_status_in = pend_status_ff;
      pend_id_in     = pend_id_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_status_in  = rsp_status_ff;
      rsp_id_in      = rsp_id_ff;
      wr_en          = 1'b0;
      wr_addr        = fill_ptr_ff[AW-1:0];
      wr_data        = fill_val_ff;

      if (rd_issue) begin
         rd_ptr_in = rd_ptr_ff + CW'(1);
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               arg_in     = req_size_or_id;
               rd_ptr_in  = '0;
               run_in     = '0;
               dst_in     = '0;
               found_in   = 1'b0;
               pend_id_in = '0;
               unique case (req_opcode)
                  ffca_pkg::OP_ALLOC: begin
                     op_in = ffca_pkg::OP_ALLOC;
                     if (req_size_or_id == '0 || req_size_or_id > IW'(n_cells) ||
                         next_id_ff >= ffca_pkg::ID_EXHAUSTED) begin
                        pend_status_in = ffca_pkg::ST_FAIL;
                        state_in       = S_DONE;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  ffca_pkg::OP_ERASE: begin
                     op_in = ffca_pkg::OP_ERASE;
                     if (req_size_or_id == '0) begin
                        pend_status_in = ffca_pkg::ST_ILLEGAL;
                        state_in       = S_DONE;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  ffca_pkg::OP_DEFRAG: begin
                     op_in    = ffca_pkg::OP_DEFRAG;
                     state_in = S_SCAN;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_SCAN: begin
            unique case (op_ff)
               ffca_pkg::OP_ALLOC: begin
                  if (rd_vld_ff) begin
                     if (rd_data_ff == '0) begin
                        run_in = run_inc;
                        if (run_inc == want) begin
                           // run complete: tag it in the fill pass
                           fill_ptr_in  = CW'(rd_idx_ff) + CW'(1) - want;
                           fill_stop_in = CW'(rd_idx_ff) + CW'(1);
                           fill_val_in  = next_id_ff;
                           state_in     = S_FILL;
                        end
                     end else begin
                        run_in = '0;
                     end
                  end else if (scan_end) begin
                     pend_status_in = ffca_pkg::ST_FAIL;
                     state_in       = S_DONE;
                  end
               end
               ffca_pkg::OP_ERASE: begin
                  if (rd_vld_ff) begin
                     if (rd_data_ff == arg_ff) begin
                        wr_en    = 1'b1;
                        wr_addr  = rd_idx_ff;
                        wr_data  = '0;
                        found_in = 1'b1;
                     end
                  end else if (scan_end) begin
                     if (found_ff) begin
                        state_in = S_IDLE;
                     end else begin
                        pend_status_in = ffca_pkg::ST_ILLEGAL;
                        state_in       = S_DONE;
                     end
                  end
               end
               default: begin
                  // compaction: writes land only on cells already read
                  if (rd_vld_ff) begin
                     if (rd_data_ff != '0) begin
                        wr_en   = 1'b1;
                        wr_addr = dst_ff[AW-1:0];
                        wr_data = rd_data_ff;
                        dst_in  = dst_ff + CW'(1);
                     end
                  end else if (scan_end) begin
                     fill_ptr_in  = dst_ff;
                     fill_stop_in = n_cells;
                     fill_val_in  = '0;
                     state_in     = S_FILL;
                  end
               end
            endcase
         end
         S_FILL: begin
            if (fill_ptr_ff != fill_stop_ff) begin
               wr_en       = 1'b1;
               fill_ptr_in = fill_ptr_ff + CW'(1);
            end else if (op_ff == ffca_pkg::OP_ALLOC) begin
               next_id_in     = next_id_ff + IW'(1);
               pend_status_in = ffca_pkg::ST_OK;
               pend_id_in     = fill_val_ff;
               state_in       = S_DONE;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = pend_status_ff;
               rsp_id_in     = pend_id_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         // reset enters the fill pass as a defragment tail over the whole store
         state_ff     <= S_FILL;
         op_ff        <= ffca_pkg::OP_DEFRAG;
         rd_ptr_ff    <= '0;
         rd_vld_ff    <= 1'b0;
         run_ff       <= '0;
         dst_ff       <= '0;
         found_ff     <= 1'b0;
         fill_ptr_ff  <= '0;
         fill_stop_ff <= CW'(ffca_pkg::MAX_CELLS);
         fill_val_ff  <= '0;
         next_id_ff   <= IW'(1);
         cells_ff     <= ffca_pkg::CELLS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff       <= state_in;
         op_ff          <= op_in;
         arg_ff         <= arg_in;
         rd_ptr_ff      <= rd_ptr_in;
         rd_vld_ff      <= rd_vld_in;
         run_ff         <= run_in;
         dst_ff         <= dst_in;
         found_ff       <= found_in;
         fill_ptr_ff    <= fill_ptr_in;
         fill_stop_ff   <= fill_stop_in;
         fill_val_ff    <= fill_val_in;
         next_id_ff     <= next_id_in;
         if (csr_valid) begin
            cells_ff <= csr_cells_in_use;
         end
         pend_status_ff <= pend_status_in;
         pend_id_ff     <= pend_id_in;
         rsp_valid_ff   <= rsp_valid_in;
         rsp_status_ff  <= rsp_status_in;
         rsp_id_ff      <= rsp_id_in;
      end
   end

   `FFCA_ASSERT_IMPL(a_ok_has_id, clock, reset, rsp_valid_ff && rsp_status_ff == ffca_pkg::ST_OK, rsp_id_ff != '0, "allocated response without id")
   `FFCA_ASSERT_IMPL(a_fail_no_id, clock, reset, rsp_valid_ff && rsp_status_ff != ffca_pkg::ST_OK, rsp_id_ff == '0, "failed response carries an id")
   `FFCA_ASSERT_IMPL(a_no_rw_clash, clock, reset, wr_en && state_ff == S_SCAN && rd_issue, wr_addr != rd_addr, "scan write hits the cell being read")
   `FFCA_ASSERT_NEVER(a_id_nonzero, clock, reset, next_id_ff == '0, "next id wrapped to zero")

endmodule

`default_nettype wire
